FILE: rtl/masked_mean_ema_tracker_unit_macros.svh
// assertion helpers for the tracker
`ifndef MASKED_MEAN_EMA_TRACKER_UNIT_MACROS_SVH
`define MASKED_MEAN_EMA_TRACKER_UNIT_MACROS_SVH

// same-cycle implication
`define MMET_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MMET_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mmet_pkg.sv
package mmet_pkg;

   localparam int ELEM_COUNT_DEF = 32;
   localparam int ELEM_W    = 6;
   localparam int SK_W      = 16;
   localparam int CFG_W     = 17;
   localparam int CNT_W     = 17;
   localparam int SUM_W     = 33;
   localparam int AVG_W     = 32;
   localparam int FRAC_W    = 17;
   localparam int DIV_W     = 33;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] CELLS_RST = 17'd1024;
   localparam logic [CFG_W-1:0] LEN_RST   = 17'd256;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN   = 2'd1;

   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

   typedef enum logic [1:0] {
      DIV_FRAC,
      DIV_FEMA,
      DIV_MEAN,
      DIV_SEMA
   } div_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        acc_rd;
      logic        acc_wr;
      logic        sw_rd;
      logic        sw_ld;
      logic        div_start;
      div_sel_type div_sel;
      logic        div_take;
      logic        sw_wr;
      logic        emit;
      logic        idx_inc;
      logic        sweep_done;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cell_end;
      logic div_done;
      logic div_busy;
      logic cnt_zero;
      logic seeded;
      logic out_free;
      logic idx_last;
   } sts_type;

endpackage

FILE: rtl/mmet_ram.sv
module mmet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/mmet_div.sv
module mmet_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [mmet_pkg::DIV_W-1:0] dividend,
   input  logic [mmet_pkg::CFG_W-1:0] divisor,
   output logic                       busy,
   output logic                       done,
   output logic [mmet_pkg::DIV_W-1:0] quotient
);

   localparam int DW = mmet_pkg::DIV_W;
   localparam int RW = mmet_pkg::CFG_W;
   localparam int CW = $clog2(DW);

   logic [DW-1:0] quo_ff, quo_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;
   logic [RW:0]   trial, diff;
   logic          fits;

   // one restoring step per cycle, msb first
   always_comb begin
      trial  = {rem_ff, quo_ff[DW-1]};
      diff   = trial - {1'b0, divisor};
      fits   = (trial >= {1'b0, divisor});
      rem_in = fits ? diff[RW-1:0] : trial[RW-1:0];
      quo_in = {quo_ff[DW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         quo_ff  <= dividend;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/mmet_ctrl.sv
module mmet_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  mmet_pkg::sts_type sts,
   output mmet_pkg::cmd_type cmd,
   output logic              req_stall
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_SW_RD,
      ST_SW_LD,
      ST_FRAC_GO,
      ST_FRAC_WT,
      ST_FEMA_GO,
      ST_FEMA_WT,
      ST_MEAN_GO,
      ST_MEAN_WT,
      ST_SEMA_GO,
      ST_SEMA_WT,
      ST_SW_WR,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = mmet_pkg::DIV_FRAC;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_ACC_RD;
         end
         ST_ACC_RD: begin
            cmd.acc_rd = 1'b1;
            state_in   = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            cmd.acc_wr = 1'b1;
            if (sts.cell_end) state_in = ST_SW_RD;
            else if (req_accept) state_in = ST_ACC_RD;
            else state_in = ST_IDLE;
         end
         ST_SW_RD: begin
            cmd.sw_rd = 1'b1;
            state_in  = ST_SW_LD;
         end
         ST_SW_LD: begin
            cmd.sw_ld = 1'b1;
            state_in  = ST_FRAC_GO;
         end
         ST_FRAC_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_FRAC_WT;
         end
         ST_FRAC_WT: begin
            if (sts.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = ST_FEMA_GO;
            end
         end
         ST_FEMA_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = mmet_pkg::DIV_FEMA;
            state_in      = ST_FEMA_WT;
         end
         ST_FEMA_WT: begin
            cmd.div_sel = mmet_pkg::DIV_FEMA;
            if (sts.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = sts.cnt_zero ? ST_SW_WR : ST_MEAN_GO;
            end
         end
         ST_MEAN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = mmet_pkg::DIV_MEAN;
            state_in      = ST_MEAN_WT;
         end
         ST_MEAN_WT: begin
            cmd.div_sel = mmet_pkg::DIV_MEAN;
            if (sts.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = sts.seeded ? ST_SEMA_GO : ST_SW_WR;
            end
         end
         ST_SEMA_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = mmet_pkg::DIV_SEMA;
            state_in      = ST_SEMA_WT;
         end
         ST_SEMA_WT: begin
            cmd.div_sel = mmet_pkg::DIV_SEMA;
            if (sts.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = ST_SW_WR;
            end
         end
         ST_SW_WR: begin
            cmd.sw_wr = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.idx_last) begin
                  cmd.sweep_done = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_SW_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // cells are taken while idle or while a non-final cell is written back
   assign req_stall = !((state_ff == ST_IDLE) ||
                        ((state_ff == ST_ACC_WR) && !sts.cell_end));

endmodule

FILE: rtl/mmet_dp.sv
module mmet_dp #(
   parameter int ELEM_COUNT = mmet_pkg::ELEM_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mmet_pkg::cmd_type                    cmd,
   output mmet_pkg::sts_type                    sts,
   input  logic                                 req_accept,
   input  logic        [mmet_pkg::ELEM_W-1:0]    req_element,
   input  logic signed [mmet_pkg::SK_W-1:0]      req_sk_value,
   input  logic signed [mmet_pkg::SK_W-1:0]      req_sigma_value,
   input  logic                                 req_frame_end,
   input  logic                                 csr_we,
   input  logic        [mmet_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [mmet_pkg::CFG_W-1:0]     csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic        [mmet_pkg::ELEM_W-1:0]    rsp_out_element,
   output logic signed [mmet_pkg::SK_W-1:0]      rsp_ema_sk,
   output logic                                 rsp_has_value,
   output logic        [mmet_pkg::FRAC_W-1:0]    rsp_valid_frac,
   output logic                                 rsp_last
);

   localparam int AW    = (ELEM_COUNT > 1) ? $clog2(ELEM_COUNT) : 1;
   localparam int EW    = mmet_pkg::ELEM_W;
   localparam int CW    = mmet_pkg::CFG_W;
   localparam int NW    = mmet_pkg::CNT_W;
   localparam int SW    = mmet_pkg::SUM_W;
   localparam int VW    = mmet_pkg::AVG_W;
   localparam int DW    = mmet_pkg::DIV_W;
   localparam int ACC_W = SW + NW;
   localparam int HIS_W = 1 + VW + VW;

   // configuration registers
   logic [CW-1:0] cells_ff, len_ff, cells_eff, len_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= mmet_pkg::CELLS_RST;
         len_ff   <= mmet_pkg::LEN_RST;
      end else if (csr_we) begin
         if (csr_index == mmet_pkg::CSR_CELLS) cells_ff <= csr_wdata;
         if (csr_index == mmet_pkg::CSR_LEN)   len_ff   <= csr_wdata;
      end
   end

   assign cells_eff = (cells_ff == '0) ? CW'(1) : cells_ff;
   assign len_eff   = (len_ff == '0) ? CW'(1) : len_ff;

   // captured cell
   logic        [EW-1:0] elem_ff;
   logic signed [15:0]   sk_ff;
   logic                 masked_ff, end_ff, in_range;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         elem_ff   <= req_element;
         sk_ff     <= req_sk_value;
         masked_ff <= req_sigma_value[15];
         end_ff    <= req_frame_end;
      end
   end

   assign in_range = ({1'b0, elem_ff} < (EW + 1)'(ELEM_COUNT));

   // sweep index
   logic [AW-1:0] idx_ff;
   logic          idx_last;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   assign idx_last = (idx_ff == AW'(ELEM_COUNT - 1));

   // accumulator memory with per-entry valid bits
   logic [ACC_W-1:0] acc_rdata, acc_wdata;
   logic [AW-1:0]    acc_raddr, acc_waddr;
   logic             acc_we, acc_upd;
   logic [(1<<AW)-1:0] acc_vld_ff;
   logic             acc_vld_rd_ff;

   assign acc_upd   = cmd.acc_wr && in_range && !masked_ff;
   assign acc_we    = acc_upd || cmd.sw_wr;
   assign acc_raddr = cmd.acc_rd ? elem_ff[AW-1:0] : idx_ff;
   assign acc_waddr = cmd.acc_wr ? elem_ff[AW-1:0] : idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= '0;
      end else if (acc_we) begin
         acc_vld_ff[acc_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_rd || cmd.sw_rd) begin
         acc_vld_rd_ff <= acc_vld_ff[acc_raddr];
      end
   end

   mmet_ram #(.WIDTH(ACC_W), .DEPTH(ELEM_COUNT)) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (acc_waddr),
      .wdata (acc_wdata),
      .re    (cmd.acc_rd || cmd.sw_rd),
      .raddr (acc_raddr),
      .rdata (acc_rdata)
   );

   // saturating accumulate
   logic signed [SW-1:0] old_sum, new_sum;
   logic        [NW-1:0] old_cnt, new_cnt;
   logic signed [SW:0]   sum_wide;

   always_comb begin
      old_sum  = acc_vld_rd_ff ? $signed(acc_rdata[ACC_W-1:NW]) : '0;
      old_cnt  = acc_vld_rd_ff ? acc_rdata[NW-1:0] : '0;
      sum_wide = (SW + 1)'(old_sum) + (SW + 1)'(sk_ff);
      if (sum_wide[SW] != sum_wide[SW-1]) begin
         new_sum = sum_wide[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
      end else begin
         new_sum = sum_wide[SW-1:0];
      end
      new_cnt  = (old_cnt == mmet_pkg::CNT_MAX) ? old_cnt : old_cnt + 1'b1;
      acc_wdata = cmd.sw_wr ? '0 : {new_sum, new_cnt};
   end

   // tracking memory, entries read as zero until the first sweep ends
   logic [HIS_W-1:0] his_rdata;
   logic             his_init_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         his_init_ff <= 1'b0;
      end else if (cmd.sweep_done) begin
         his_init_ff <= 1'b1;
      end
   end

   // working registers for one element
   logic        [NW-1:0] cnt_ff;
   logic signed [SW-1:0] sum_ff;
   logic signed [VW-1:0] avg_ff, mean_ff;
   logic        [VW-1:0] fav_ff, ftgt_ff;
   logic                 seed_ff;

   mmet_ram #(.WIDTH(HIS_W), .DEPTH(ELEM_COUNT)) u_his_ram (
      .clock (clock),
      .we    (cmd.sw_wr),
      .waddr (idx_ff),
      .wdata ({seed_ff, avg_ff, fav_ff}),
      .re    (cmd.sw_rd),
      .raddr (idx_ff),
      .rdata (his_rdata)
   );

   // shared divider operands
   logic signed [DW-1:0] fdiff, sdiff;
   logic        [DW-1:0] div_a, div_q;
   logic        [CW-1:0] div_b;
   logic                 div_done, div_busy, sum_neg;

   always_comb begin
      fdiff   = $signed({1'b0, ftgt_ff}) - $signed({1'b0, fav_ff});
      sdiff   = DW'(mean_ff) - DW'(avg_ff);
      sum_neg = sum_ff[SW-1];
      case (cmd.div_sel)
         mmet_pkg::DIV_FRAC: begin
            div_a = {cnt_ff, 16'b0};
            div_b = cells_eff;
         end
         mmet_pkg::DIV_FEMA: begin
            div_a = fdiff[DW-1] ? DW'(-fdiff) : DW'(fdiff);
            div_b = len_eff;
         end
         mmet_pkg::DIV_MEAN: begin
            div_a = sum_neg ? DW'(-sum_ff) : DW'(sum_ff);
            div_b = cnt_ff;
         end
         mmet_pkg::DIV_SEMA: begin
            div_a = sdiff[DW-1] ? DW'(-sdiff) : DW'(sdiff);
            div_b = len_eff;
         end
         default: begin
            div_a = '0;
            div_b = len_eff;
         end
      endcase
   end

   mmet_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   // clamped mean in Q4.12
   logic signed [15:0] mean16;

   always_comb begin
      if (sum_neg) begin
         mean16 = (div_q > DW'(32768)) ? 16'sh8000 : 16'(-div_q);
      end else begin
         mean16 = (div_q > DW'(32767)) ? 16'sh7fff : 16'(div_q);
      end
   end

   // per-element update
   always_ff @(posedge clock) begin
      if (cmd.sw_ld) begin
         cnt_ff  <= acc_vld_rd_ff ? acc_rdata[NW-1:0] : '0;
         sum_ff  <= acc_vld_rd_ff ? $signed(acc_rdata[ACC_W-1:NW]) : '0;
         seed_ff <= his_init_ff ? his_rdata[HIS_W-1] : 1'b0;
         avg_ff  <= his_init_ff ? $signed(his_rdata[HIS_W-2:VW]) : '0;
         fav_ff  <= his_init_ff ? his_rdata[VW-1:0] : '0;
      end else if (cmd.div_take) begin
         case (cmd.div_sel)
            mmet_pkg::DIV_FRAC: begin
               ftgt_ff <= (div_q > DW'(mmet_pkg::FRAC_ONE)) ?
                          {mmet_pkg::FRAC_ONE, 15'b0} : {div_q[16:0], 15'b0};
            end
            mmet_pkg::DIV_FEMA: begin
               fav_ff <= fdiff[DW-1] ? fav_ff - div_q[VW-1:0] : fav_ff + div_q[VW-1:0];
            end
            mmet_pkg::DIV_MEAN: begin
               mean_ff <= {mean16, 16'b0};
               if (!seed_ff) begin
                  avg_ff  <= {mean16, 16'b0};
                  seed_ff <= 1'b1;
               end
            end
            mmet_pkg::DIV_SEMA: begin
               avg_ff <= sdiff[DW-1] ? avg_ff - $signed(div_q[VW-1:0]) :
                                       avg_ff + $signed(div_q[VW-1:0]);
            end
            default: begin
               avg_ff <= avg_ff;
            end
         endcase
      end
   end

   // output register
   logic valid_ff, out_free;

   assign out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_out_element <= EW'(idx_ff);
         rsp_ema_sk      <= seed_ff ? avg_ff[VW-1:16] : '0;
         rsp_has_value   <= seed_ff;
         rsp_valid_frac  <= fav_ff[VW-1:15];
         rsp_last        <= idx_last;
      end
   end

   assign rsp_valid = valid_ff;

   always_comb begin
      sts          = '0;
      sts.cell_end = end_ff;
      sts.div_done = div_done;
      sts.div_busy = div_busy;
      sts.cnt_zero = (cnt_ff == '0);
      sts.seeded   = seed_ff;
      sts.out_free = out_free;
      sts.idx_last = idx_last;
   end

endmodule

FILE: rtl/masked_mean_ema_tracker_unit.sv
// Per-element masked mean SK tracker.
// Input channel req_*: one cell per transaction (element, SK in Q4.12, sigma,
// frame_end). A cell with negative sigma, or an element not below
// ELEM_COUNT, leaves the accumulators alone.
// A cell takes one accumulator read and one write back; the next cell is
// taken during the write back, so cells are taken back to back.
// On a cell with frame_end the block sweeps all elements. Each element costs
// memory access and result hand-off plus one pass through the shared
// 33-step divider per quotient: fraction and fraction average with no valid
// cell in the frame, also the mean on its first valid frame, and also the SK
// average after that. During the sweep req_stall stays high.
// Result channel rsp_*: one transaction per element, in element order, with
// rsp_last on the final one. Results pass through an output register, so the
// sweep stops on a stalled result and resumes when it is taken; the next
// cell is taken while the last result still waits.
// Configuration via csr_we/csr_index/csr_wdata, only while idle.
// Synchronous reset restores register defaults and clears all averages and
// accumulators at once; no clearing pass is needed.
`include "masked_mean_ema_tracker_unit_macros.svh"

module masked_mean_ema_tracker_unit #(
   parameter int ELEM_COUNT = mmet_pkg::ELEM_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic        [mmet_pkg::ELEM_W-1:0]    req_element,
   input  logic signed [mmet_pkg::SK_W-1:0]      req_sk_value,
   input  logic signed [mmet_pkg::SK_W-1:0]      req_sigma_value,
   input  logic                                 req_frame_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic        [mmet_pkg::ELEM_W-1:0]    rsp_out_element,
   output logic signed [mmet_pkg::SK_W-1:0]      rsp_ema_sk,
   output logic                                 rsp_has_value,
   output logic        [mmet_pkg::FRAC_W-1:0]    rsp_valid_frac,
   output logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic        [mmet_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [mmet_pkg::CFG_W-1:0]     csr_wdata
);

   mmet_pkg::cmd_type cmd;
   mmet_pkg::sts_type sts;
   logic              req_accept;

   assign req_accept = req_valid && !req_stall;

   // sequencer
   mmet_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .sts        (sts),
      .cmd        (cmd),
      .req_stall  (req_stall)
   );

   // storage and arithmetic
   mmet_dp #(.ELEM_COUNT(ELEM_COUNT)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_accept      (req_accept),
      .req_element     (req_element),
      .req_sk_value    (req_sk_value),
      .req_sigma_value (req_sigma_value),
      .req_frame_end   (req_frame_end),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_element (rsp_out_element),
      .rsp_ema_sk      (rsp_ema_sk),
      .rsp_has_value   (rsp_has_value),
      .rsp_valid_frac  (rsp_valid_frac),
      .rsp_last        (rsp_last)
   );

   // checks
   `MMET_ASSERT_NOW(a_div_idle_start, cmd.div_start, !sts.div_busy, "divider restarted while busy")
   `MMET_ASSERT_NOW(a_emit_free, cmd.emit, sts.out_free, "result overwritten before taken")
   `MMET_ASSERT_NOW(a_sweep_holds_input, rsp_valid && !rsp_last, req_stall, "cell taken mid sweep")
   `MMET_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid, "stalled result dropped")

endmodule

FILE: sim/masked_mean_ema_tracker_unit_check.sv
module masked_mean_ema_tracker_unit_check #(
   parameter int ELEM_COUNT = mmet_pkg::ELEM_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic        [mmet_pkg::ELEM_W-1:0]    req_element,
   input  logic signed [mmet_pkg::SK_W-1:0]      req_sk_value,
   input  logic signed [mmet_pkg::SK_W-1:0]      req_sigma_value,
   input  logic                                 req_frame_end,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic        [mmet_pkg::ELEM_W-1:0]    rsp_out_element,
   input  logic signed [mmet_pkg::SK_W-1:0]      rsp_ema_sk,
   input  logic                                 rsp_has_value,
   input  logic        [mmet_pkg::FRAC_W-1:0]    rsp_valid_frac,
   input  logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic        [mmet_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [mmet_pkg::CFG_W-1:0]     csr_wdata,
   output int                                   error_count,
   output int                                   pending_count
);

   typedef struct packed {
      logic [mmet_pkg::ELEM_W-1:0]      element;
      logic signed [mmet_pkg::SK_W-1:0] ema_sk;
      logic                             has_value;
      logic [mmet_pkg::FRAC_W-1:0]      frac;
      logic                             last;
   } update_type;

   update_type      update_queue[$];
   logic [mmet_pkg::CFG_W-1:0] cells_reg, len_reg;
   longint          frame_sum[ELEM_COUNT];
   longint          frame_count[ELEM_COUNT];
   longint          sk_avg[ELEM_COUNT];
   longint          frac_avg[ELEM_COUNT];
   bit              seeded[ELEM_COUNT];

   assign pending_count = update_queue.size();

   // ema step with division truncated toward zero
   function automatic longint ema_step(longint avg, longint target, longint n);
      longint d;
      d = target - avg;
      if (d < 0) return avg - ((-d) / n);
      return avg + d / n;
   endfunction

   // accumulate one cell, sweep elements on frame end
   task automatic track_cell(logic [mmet_pkg::ELEM_W-1:0] e,
                             logic signed [mmet_pkg::SK_W-1:0] sk,
                             logic signed [mmet_pkg::SK_W-1:0] sg, logic fe);
      longint cells, n, frac, mean, s;
      update_type u;
      cells = (cells_reg == 0) ? 1 : cells_reg;
      n = (len_reg == 0) ? 1 : len_reg;
      if (e < ELEM_COUNT && sg >= 0) begin
         s = frame_sum[e] + sk;
         if (s > 64'sd4294967295) s = 64'sd4294967295;
         if (s < -64'sd4294967296) s = -64'sd4294967296;
         frame_sum[e] = s;
         if (frame_count[e] < 131071) frame_count[e]++;
      end
      if (!fe) return;
      for (int k = 0; k < ELEM_COUNT; k++) begin
         frac = (frame_count[k] * 65536) / cells;
         if (frac > 65536) frac = 65536;
         frac_avg[k] = ema_step(frac_avg[k], frac * 32768, n) & 64'hFFFF_FFFF;
         if (frame_count[k] > 0) begin
            if (frame_sum[k] < 0) mean = -((-frame_sum[k]) / frame_count[k]);
            else mean = frame_sum[k] / frame_count[k];
            if (mean > 32767) mean = 32767;
            if (mean < -32768) mean = -32768;
            mean = mean * 65536;
            if (seeded[k]) sk_avg[k] = ema_step(sk_avg[k], mean, n);
            else sk_avg[k] = mean;
            // keep as signed 32-bit
            sk_avg[k] = longint'($signed(sk_avg[k][31:0]));
            seeded[k] = 1;
         end
         u.element = mmet_pkg::ELEM_W'(k);
         u.ema_sk = seeded[k] ? mmet_pkg::SK_W'(sk_avg[k] >>> 16) : '0;
         u.has_value = seeded[k];
         u.frac = mmet_pkg::FRAC_W'(frac_avg[k] >> 15);
         u.last = (k == ELEM_COUNT - 1);
         update_queue.insert(update_queue.size(), u);
         frame_sum[k] = 0;
         frame_count[k] = 0;
      end
   endtask

   // watch the channels at each rising edge
   always @(posedge clock) begin
      update_type x;
      if (reset) begin
         cells_reg <= mmet_pkg::CELLS_RST;
         len_reg <= mmet_pkg::LEN_RST;
         error_count <= 0;
         update_queue.delete();
         for (int k = 0; k < ELEM_COUNT; k++) begin
            frame_sum[k] = 0; frame_count[k] = 0; sk_avg[k] = 0;
            frac_avg[k] = 0; seeded[k] = 0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index == mmet_pkg::CSR_CELLS) cells_reg <= csr_wdata;
            else if (csr_index == mmet_pkg::CSR_LEN) len_reg <= csr_wdata;
         end
         if (req_valid && !req_stall)
            track_cell(req_element, req_sk_value, req_sigma_value, req_frame_end);
         if (rsp_valid && !rsp_stall) begin
            if (update_queue.size() == 0) begin
               if (error_count < 10) $display("unexpected update elem %0d", rsp_out_element);
               error_count <= error_count + 1;
            end else begin
               x = update_queue.pop_front();
               if (x.element !== rsp_out_element || x.ema_sk !== rsp_ema_sk ||
                   x.has_value !== rsp_has_value || x.frac !== rsp_valid_frac ||
                   x.last !== rsp_last) begin
                  if (error_count < 10)
                     $display("mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                        x.element, x.ema_sk, x.has_value, x.frac, x.last, rsp_out_element,
                        rsp_ema_sk, rsp_has_value, rsp_valid_frac, rsp_last);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: sim/masked_mean_ema_tracker_unit_test.sv
module masked_mean_ema_tracker_unit_test;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, req_frame_end = 0;
   logic [mmet_pkg::ELEM_W-1:0] req_element = 0;
   logic signed [mmet_pkg::SK_W-1:0] req_sk_value = 0, req_sigma_value = 0;
   logic rsp_valid, rsp_stall = 0, rsp_has_value, rsp_last;
   logic [mmet_pkg::ELEM_W-1:0] rsp_out_element;
   logic signed [mmet_pkg::SK_W-1:0] rsp_ema_sk;
   logic [mmet_pkg::FRAC_W-1:0] rsp_valid_frac;
   logic csr_we = 0;
   logic [mmet_pkg::CSR_IDX_W-1:0] csr_index = mmet_pkg::CSR_CELLS;
   logic [mmet_pkg::CFG_W-1:0] csr_wdata = 0;
   int error_count, pending_count, quiet_cycles = 0;
   bit calm = 0, hold_off = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   masked_mean_ema_tracker_unit DUT (.*);
   masked_mean_ema_tracker_unit_check checker_inst (.*);

   // receiver stall pattern
   always @(negedge clock)
      rsp_stall <= hold_off || (!calm && $urandom_range(99) < 30);

   // watchdog on accepted transactions
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // valid stays high after the transaction until the next one or a pause
   task automatic send_cell(int e, int sk, int sg, bit fe);
      while (!calm && $urandom_range(99) < 30) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_element <= mmet_pkg::ELEM_W'(e);
      req_sk_value <= mmet_pkg::SK_W'(sk);
      req_sigma_value <= mmet_pkg::SK_W'(sg);
      req_frame_end <= fe;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_reg(logic [mmet_pkg::CSR_IDX_W-1:0] idx, int v);
      csr_we <= 1; csr_index <= idx; csr_wdata <= mmet_pkg::CFG_W'(v);
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
   endtask

   // random frame with mostly valid cells, mostly for in-range elements
   task automatic random_frame(int cells);
      for (int i = 0; i < cells; i++)
         send_cell($urandom_range(99) < 90 ? $urandom_range(31) : $urandom_range(63),
                   int'($urandom),
                   $urandom_range(99) < 75 ? $urandom_range(32767) : int'($urandom),
                   i == cells - 1);
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: field extremes, masking, out of range element, seeding
      send_cell(0, 32767, 0, 0);
      send_cell(0, 32767, 32767, 0);
      send_cell(1, -32768, 5, 0);
      send_cell(2, 100, -1, 0);
      send_cell(2, -100, -32768, 0);
      send_cell(63, 5, 5, 0);
      send_cell(40, 5, 5, 0);
      send_cell(31, 16'h5555, 0, 0);
      send_cell(31, 16'hAAAA, 0, 1);
      drain();
      // zero registers act as one; more valid cells than configured saturate the fraction
      write_reg(mmet_pkg::CSR_CELLS, 0);
      write_reg(mmet_pkg::CSR_LEN, 0);
      send_cell(3, -7, 1, 0);
      send_cell(3, 2, 1, 0);
      send_cell(0, 1, 1, 1);
      drain();
      write_reg(mmet_pkg::CSR_CELLS, 131071);
      write_reg(mmet_pkg::CSR_LEN, 131071);
      send_cell(5, 1234, 9, 1);
      drain();
      write_reg(mmet_pkg::CSR_CELLS, 65536);
      write_reg(mmet_pkg::CSR_LEN, 65536);
      send_cell(5, -1234, 9, 1);
      drain();
      write_reg(mmet_pkg::CSR_CELLS, 1);
      write_reg(mmet_pkg::CSR_LEN, 1);
      send_cell(6, 7, 9, 1);
      drain();
      // random frames, first with no random stalls; settings change before each later pair
      calm = 1;
      random_frame(20);
      calm = 0;
      // long receiver hold-off while cells keep coming
      hold_off = 1;
      fork
         begin repeat (400) @(negedge clock); hold_off = 0; end
         random_frame(12);
      join
      drain();
      for (int p = 0; p < 5; p++) begin
         write_reg(mmet_pkg::CSR_CELLS, $urandom_range(1, 24));
         write_reg(mmet_pkg::CSR_LEN, $urandom_range(1, 8));
         random_frame($urandom_range(8, 20));
         random_frame($urandom_range(4, 12));
         drain();
      end
      write_reg(mmet_pkg::CSR_CELLS, mmet_pkg::CELLS_RST);
      write_reg(mmet_pkg::CSR_LEN, mmet_pkg::LEN_RST);
      random_frame(10);
      drain();
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
